>>> rtl/core/sqb_pkg.sv
// ----------------------------------------------------------------------------
// sqb_pkg
// shared types and constants of the subimage atlas quad builder
// ----------------------------------------------------------------------------
package sqb_pkg;

    localparam int MAX_IMAGES = 64;
    localparam int IDX_W      = $clog2(MAX_IMAGES);
    localparam int CNT_W      = $clog2(MAX_IMAGES + 1);

    localparam int GEOM_W     = 52;
    localparam int COLOR_W    = 32;
    localparam int POS_W      = 32;
    localparam int ENTRY_W    = GEOM_W + COLOR_W + POS_W;

    localparam int DIVIDEND_W = 33;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [15:0] SAT16  = 16'hFFFF;
    localparam logic [18:0] SAT19  = 19'h7FFFF;
    localparam logic [16:0] TEXONE = 17'h10000;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_ATLAS_WIDTH = 3'd0;
    localparam logic [2:0] REG_TARGET_X        = 3'd1;
    localparam logic [2:0] REG_TARGET_Y        = 3'd2;
    localparam logic [2:0] REG_TARGET_WIDTH    = 3'd3;
    localparam logic [2:0] REG_TARGET_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_CANVAS_WIDTH    = 3'd5;
    localparam logic [2:0] REG_CANVAS_HEIGHT   = 3'd6;

    typedef struct packed {
        logic [15:0]      atlas_w;
        logic [15:0]      atlas_h;
        logic [CNT_W-1:0] count;
    } pack_status_t;

endpackage

>>> rtl/core/subimage_atlas_quad_builder.sv
// ----------------------------------------------------------------------------
// subimage_atlas_quad_builder
// shelf packs subtitle images into an atlas and builds one quad per stored image
// ----------------------------------------------------------------------------
// packing: an image beat is taken whenever in_valid is high while the sequencer is idle
// emission: after the last beat, each result costs 8 divisions, one at a time,
//   on one shared radix-2 divider; no new image is taken until the set is emitted
// reset clears the packer and sequencer; config registers take their defaults
// the image store is not cleared, only entries of the current set are read
module subimage_atlas_quad_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [12:0] image_x,
    input  logic [12:0] image_y,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    input  logic [12:0] row_stride,
    input  logic [31:0] packed_color,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] upload_x,
    output logic [15:0] upload_y,
    output logic [18:0] screen_left,
    output logic [18:0] screen_top,
    output logic [18:0] screen_right,
    output logic [18:0] screen_bottom,
    output logic [16:0] tex_left,
    output logic [16:0] tex_top,
    output logic [16:0] tex_right,
    output logic [16:0] tex_bottom,
    output logic [31:0] rgba,
    output logic        end_of_set
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_READ  = 6'b000100,
        S_DIV   = 6'b001000,
        S_WAIT  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        STEP_X   = 3'd0,
        STEP_W   = 3'd1,
        STEP_Y   = 3'd2,
        STEP_H   = 3'd3,
        STEP_TL  = 3'd4,
        STEP_TR  = 3'd5,
        STEP_TT  = 3'd6,
        STEP_TB  = 3'd7
    } step_t;

    // configuration
    logic [13:0] max_aw_reg, tx_reg, ty_reg, tw_reg, th_reg, cw_reg, ch_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_aw_reg <= 14'd4096;
            tx_reg     <= '0;
            ty_reg     <= '0;
            tw_reg     <= '0;
            th_reg     <= '0;
            cw_reg     <= 14'd1;
            ch_reg     <= 14'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                sqb_pkg::REG_MAX_ATLAS_WIDTH: max_aw_reg <= pwdata[13:0];
                sqb_pkg::REG_TARGET_X:        tx_reg     <= pwdata[13:0];
                sqb_pkg::REG_TARGET_Y:        ty_reg     <= pwdata[13:0];
                sqb_pkg::REG_TARGET_WIDTH:    tw_reg     <= pwdata[13:0];
                sqb_pkg::REG_TARGET_HEIGHT:   th_reg     <= pwdata[13:0];
                sqb_pkg::REG_CANVAS_WIDTH:    cw_reg     <= pwdata[13:0];
                sqb_pkg::REG_CANVAS_HEIGHT:   ch_reg     <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            sqb_pkg::REG_MAX_ATLAS_WIDTH: prdata = {18'b0, max_aw_reg};
            sqb_pkg::REG_TARGET_X:        prdata = {18'b0, tx_reg};
            sqb_pkg::REG_TARGET_Y:        prdata = {18'b0, ty_reg};
            sqb_pkg::REG_TARGET_WIDTH:    prdata = {18'b0, tw_reg};
            sqb_pkg::REG_TARGET_HEIGHT:   prdata = {18'b0, th_reg};
            sqb_pkg::REG_CANVAS_WIDTH:    prdata = {18'b0, cw_reg};
            sqb_pkg::REG_CANVAS_HEIGHT:   prdata = {18'b0, ch_reg};
            default:                      prdata = '0;
        endcase
    end

    // sequencer state
    state_t                    state_reg, state_next;
    step_t                     step_reg, step_next;
    logic [sqb_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [sqb_pkg::DIVIDEND_W-1:0] q_reg [8];
    logic                      out_valid_reg, out_valid_next;

    logic                      in_beat;
    logic                      clear;
    logic                      store_we;
    logic [sqb_pkg::IDX_W-1:0] store_addr;
    logic [sqb_pkg::POS_W-1:0] store_pos;
    sqb_pkg::pack_status_t     status;
    logic [sqb_pkg::ENTRY_W-1:0] rdata;

    logic                      div_start, div_busy, div_done;
    logic [sqb_pkg::DIVIDEND_W-1:0] div_dividend, div_quotient;
    logic [sqb_pkg::DIVISOR_W-1:0]  div_divisor;

    logic                      out_free;
    logic                      load_out;
    logic                      last_entry;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_entry = ({1'b0, idx_reg} + 1'b1) == status.count;
    assign load_out = (state_reg == S_EMIT) && out_free;

    sqb_pack u_pack (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (in_beat),
        .clear           (clear),
        .max_atlas_width (max_aw_reg),
        .image_width     (image_width),
        .image_height    (image_height),
        .row_stride      (row_stride),
        .store_we        (store_we),
        .store_addr      (store_addr),
        .store_pos       (store_pos),
        .status          (status)
    );

    sqb_ram #(
        .WIDTH (sqb_pkg::ENTRY_W),
        .DEPTH (sqb_pkg::MAX_IMAGES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_addr),
        .wdata ({store_pos, packed_color, image_height, image_width, image_y, image_x}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // fields of the entry being emitted
    logic [12:0] gx, gy, gw, gh;
    logic [31:0] color;
    logic [15:0] ux, uy;

    assign gx    = rdata[12:0];
    assign gy    = rdata[25:13];
    assign gw    = rdata[38:26];
    assign gh    = rdata[51:39];
    assign color = rdata[83:52];
    assign ux    = rdata[99:84];
    assign uy    = rdata[115:100];

    // operand selection for the shared divider
    logic [12:0] mul_a;
    logic [13:0] mul_b;
    logic [26:0] product;
    logic [13:0] canvas;
    logic [16:0] tex_num;
    logic        tex_step;
    logic [13:0] cw_eff, ch_eff;

    assign cw_eff = (cw_reg == '0) ? 14'd1 : cw_reg;
    assign ch_eff = (ch_reg == '0) ? 14'd1 : ch_reg;

    always_comb
    begin
        mul_a    = gx;
        mul_b    = tw_reg;
        canvas   = cw_eff;
        tex_num  = {1'b0, ux};
        tex_step = 1'b0;
        div_divisor = status.atlas_w;
        unique case (step_reg)
            STEP_X:  begin mul_a = gx; mul_b = tw_reg; canvas = cw_eff; end
            STEP_W:  begin mul_a = gw; mul_b = tw_reg; canvas = cw_eff; end
            STEP_Y:  begin mul_a = gy; mul_b = th_reg; canvas = ch_eff; end
            STEP_H:  begin mul_a = gh; mul_b = th_reg; canvas = ch_eff; end
            STEP_TL: begin tex_num = {1'b0, ux}; tex_step = 1'b1; end
            STEP_TR: begin tex_num = {1'b0, ux} + {4'b0, gw}; tex_step = 1'b1; end
            STEP_TT:
            begin
                tex_num = {1'b0, uy}; tex_step = 1'b1;
                div_divisor = status.atlas_h;
            end
            STEP_TB:
            begin
                tex_num = {1'b0, uy} + {4'b0, gh}; tex_step = 1'b1;
                div_divisor = status.atlas_h;
            end
            default: ;
        endcase
        if (!tex_step)
        begin
            div_divisor = {2'b0, canvas};
        end
    end

    assign product      = mul_a * mul_b;
    assign div_dividend = tex_step ? {tex_num, 16'b0} : {2'b0, product, 4'b0};
    assign div_start    = (state_reg == S_DIV);

    sqb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        clear      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat && last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                idx_next = '0;
                if (status.count == '0)
                begin
                    clear      = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                step_next  = STEP_X;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (step_reg == STEP_TB)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        step_next  = step_t'(step_reg + 3'd1);
                        state_next = S_DIV;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (last_entry)
                    begin
                        clear      = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_X;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // quotient capture; a zero atlas extent gives a zero coordinate
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WAIT) && div_done)
        begin
            if (tex_step && (div_divisor == '0))
            begin
                q_reg[step_reg] <= '0;
            end
            else
            begin
                q_reg[step_reg] <= div_quotient;
            end
        end
    end

    // result assembly
    logic [31:0] left_sum, top_sum;
    logic [32:0] right_sum, bottom_sum;

    assign left_sum   = {14'b0, tx_reg, 4'b0} + {1'b0, q_reg[STEP_X][30:0]};
    assign top_sum    = {14'b0, ty_reg, 4'b0} + {1'b0, q_reg[STEP_Y][30:0]};
    assign right_sum  = {1'b0, left_sum} + {2'b0, q_reg[STEP_W][30:0]};
    assign bottom_sum = {1'b0, top_sum} + {2'b0, q_reg[STEP_H][30:0]};

    function automatic logic [18:0] sat19(input logic [32:0] v);
        logic [18:0] r;
        r = (v > {14'b0, sqb_pkg::SAT19}) ? sqb_pkg::SAT19 : v[18:0];
        return r;
    endfunction

    function automatic logic [16:0] sat_tex(input logic [32:0] v);
        logic [16:0] r;
        r = (v > {16'b0, sqb_pkg::TEXONE}) ? sqb_pkg::TEXONE : v[16:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            upload_x      <= ux;
            upload_y      <= uy;
            screen_left   <= sat19({1'b0, left_sum});
            screen_top    <= sat19({1'b0, top_sum});
            screen_right  <= sat19(right_sum);
            screen_bottom <= sat19(bottom_sum);
            tex_left      <= sat_tex(q_reg[STEP_TL]);
            tex_right     <= sat_tex(q_reg[STEP_TR]);
            tex_top       <= sat_tex(q_reg[STEP_TT]);
            tex_bottom    <= sat_tex(q_reg[STEP_TB]);
            rgba          <= {color[31:8], 8'hff - color[7:0]};
            end_of_set    <= last_entry;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= sqb_pkg::CNT_W'(sqb_pkg::MAX_IMAGES))
        else $error("image count beyond store size");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && last_entry) |=> (state_reg == S_IDLE) && (status.count == '0))
        else $error("set not closed after final result");

    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("input ready while divider busy");

endmodule

>>> rtl/core/sqb_ram.sv
// ----------------------------------------------------------------------------
// sqb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sqb_div.sv
// ----------------------------------------------------------------------------
// sqb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sqb_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sqb_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [sqb_pkg::DIVISOR_W-1:0]       divisor,
    output logic                                busy,
    output logic                                done,
    output logic [sqb_pkg::DIVIDEND_W-1:0]      quotient
);

    logic [sqb_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [sqb_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [sqb_pkg::DIVISOR_W-1:0]  div_reg;
    logic [sqb_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [sqb_pkg::DIVISOR_W:0]    trial;
    logic [sqb_pkg::DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quo_reg[sqb_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = sqb_pkg::DIV_CNT_W'(sqb_pkg::DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[sqb_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[sqb_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[sqb_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[sqb_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sqb_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/sqb_pack.sv
// ----------------------------------------------------------------------------
// sqb_pack
// shelf packer: cursor, row and atlas extent, image count
// ----------------------------------------------------------------------------
module sqb_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          clear,
    input  logic [13:0]                   max_atlas_width,
    input  logic [12:0]                   image_width,
    input  logic [12:0]                   image_height,
    input  logic [12:0]                   row_stride,
    output logic                          store_we,
    output logic [sqb_pkg::IDX_W-1:0]     store_addr,
    output logic [sqb_pkg::POS_W-1:0]     store_pos,
    output sqb_pkg::pack_status_t         status
);

    logic [15:0]               cursor_reg, cursor_next;
    logic [15:0]               row_top_reg, row_top_next;
    logic [12:0]               row_h_reg, row_h_next;
    logic [15:0]               atlas_w_reg, atlas_w_next;
    logic [sqb_pkg::CNT_W-1:0] count_reg, count_next;

    logic                      room;
    logic                      wrap;
    logic [16:0]               wrap_sum;
    logic [16:0]               top_sum;
    logic [15:0]               top_sat;
    logic [15:0]               cur_eff;
    logic [15:0]               top_eff;
    logic [12:0]               rh_eff;
    logic [16:0]               cur_sum;

    assign room     = count_reg < sqb_pkg::CNT_W'(sqb_pkg::MAX_IMAGES);
    assign wrap_sum = {1'b0, cursor_reg} + {4'b0, row_stride};
    assign wrap     = (max_atlas_width != '0) && (wrap_sum > {3'b0, max_atlas_width});
    assign top_sum  = {1'b0, row_top_reg} + {4'b0, row_h_reg};
    assign top_sat  = top_sum[16] ? sqb_pkg::SAT16 : top_sum[15:0];
    assign cur_eff  = wrap ? '0 : cursor_reg;
    assign top_eff  = wrap ? top_sat : row_top_reg;
    assign rh_eff   = wrap ? '0 : row_h_reg;
    assign cur_sum  = {1'b0, cur_eff} + {4'b0, image_width};

    always_comb
    begin
        cursor_next  = cursor_reg;
        row_top_next = row_top_reg;
        row_h_next   = row_h_reg;
        atlas_w_next = atlas_w_reg;
        count_next   = count_reg;
        if (clear)
        begin
            cursor_next  = '0;
            row_top_next = '0;
            row_h_next   = '0;
            atlas_w_next = '0;
            count_next   = '0;
        end
        else if (take && room)
        begin
            if (wrap && (cursor_reg > atlas_w_reg))
            begin
                atlas_w_next = cursor_reg;
            end
            row_top_next = top_eff;
            cursor_next  = cur_sum[16] ? sqb_pkg::SAT16 : cur_sum[15:0];
            row_h_next   = (image_height > rh_eff) ? image_height : rh_eff;
            count_next   = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            row_top_reg <= '0;
            row_h_reg   <= '0;
            atlas_w_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            row_top_reg <= row_top_next;
            row_h_reg   <= row_h_next;
            atlas_w_reg <= atlas_w_next;
            count_reg   <= count_next;
        end
    end

    assign store_we   = take && room && !clear;
    assign store_addr = count_reg[sqb_pkg::IDX_W-1:0];
    assign store_pos  = {top_eff, cur_eff};

    assign status.atlas_w = (cursor_reg > atlas_w_reg) ? cursor_reg : atlas_w_reg;
    assign status.atlas_h = top_sat;
    assign status.count   = count_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subimage atlas quad builder testbench
// drives sets of sub-images through the valid/ready input, checks every quad
// against an in-bench shelf packer and quad calculator, over several register
// setups and sender/receiver idling patterns
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] stride;
        logic [31:0] color;
        logic        last;
    } image_t;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [18:0] sl;
        logic [18:0] st;
        logic [18:0] sr;
        logic [18:0] sb;
        logic [16:0] tl;
        logic [16:0] tt;
        logic [16:0] tr;
        logic [16:0] tb;
        logic [31:0] rgba;
        logic        eos;
    } quad_t;

    typedef struct packed {
        image_t img;
        logic   typed;
        quad_t  want;
    } dir_row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam quad_t NO_QUAD = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [12:0] image_x = '0, image_y = '0, image_width = '0, image_height = '0;
    logic [12:0] row_stride = '0;
    logic [31:0] packed_color = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] upload_x, upload_y;
    logic [18:0] screen_left, screen_top, screen_right, screen_bottom;
    logic [16:0] tex_left, tex_top, tex_right, tex_bottom;
    logic [31:0] rgba;
    logic        end_of_set;

    subimage_atlas_quad_builder i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // register shadow and packer state
    logic [13:0] cfg_regs [0:6];
    longint unsigned cur_x, row_y, row_h, atlas_w;
    int          n_stored;
    image_t      stored_img [0:sqb_pkg::MAX_IMAGES-1];
    logic [15:0] stored_ux [0:sqb_pkg::MAX_IMAGES-1];
    logic [15:0] stored_uy [0:sqb_pkg::MAX_IMAGES-1];

    quad_t pending_quads [$];

    int errors = 0;
    int n_images = 0, n_sets = 0, n_quads = 0, n_setups = 0;
    int idle_pct = 0, stall_pct = 0;
    int hold_req = 0, hold_left = 0;
    int idle_cycles = 0;

    function automatic longint unsigned sat(longint unsigned v, longint unsigned top);
        return v > top ? top : v;
    endfunction

    function automatic longint unsigned scale16(longint unsigned v, longint unsigned t,
                                                longint unsigned c);
        return (v * t * 16) / (c == 0 ? 1 : c);
    endfunction

    function automatic longint unsigned tex_coord(longint unsigned v, longint unsigned size);
        if (size == 0)
            return 0;
        return sat((v * 65536) / size, 65536);
    endfunction

    function automatic void pack_image(image_t im);
        longint unsigned aw, ah, left, top;
        quad_t q;
        if (n_stored < sqb_pkg::MAX_IMAGES)
        begin
            if (cfg_regs[sqb_pkg::REG_MAX_ATLAS_WIDTH] != 0 &&
                cur_x + im.stride > cfg_regs[sqb_pkg::REG_MAX_ATLAS_WIDTH])
            begin
                if (cur_x > atlas_w)
                    atlas_w = cur_x;
                row_y = sat(row_y + row_h, 65535);
                cur_x = 0;
                row_h = 0;
            end
            stored_img[n_stored] = im;
            stored_ux[n_stored] = cur_x[15:0];
            stored_uy[n_stored] = row_y[15:0];
            cur_x = sat(cur_x + im.w, 65535);
            if (im.h > row_h)
                row_h = im.h;
            n_stored++;
        end
        if (!im.last)
            return;
        aw = cur_x > atlas_w ? cur_x : atlas_w;
        ah = sat(row_y + row_h, 65535);
        for (int k = 0; k < n_stored; k++)
        begin
            left = 16 * cfg_regs[sqb_pkg::REG_TARGET_X] + scale16(stored_img[k].x,
                   cfg_regs[sqb_pkg::REG_TARGET_WIDTH], cfg_regs[sqb_pkg::REG_CANVAS_WIDTH]);
            top = 16 * cfg_regs[sqb_pkg::REG_TARGET_Y] + scale16(stored_img[k].y,
                  cfg_regs[sqb_pkg::REG_TARGET_HEIGHT], cfg_regs[sqb_pkg::REG_CANVAS_HEIGHT]);
            q.ux = stored_ux[k];
            q.uy = stored_uy[k];
            q.sl = 19'(sat(left, 524287));
            q.st = 19'(sat(top, 524287));
            q.sr = 19'(sat(left + scale16(stored_img[k].w,
                       cfg_regs[sqb_pkg::REG_TARGET_WIDTH],
                       cfg_regs[sqb_pkg::REG_CANVAS_WIDTH]), 524287));
            q.sb = 19'(sat(top + scale16(stored_img[k].h,
                       cfg_regs[sqb_pkg::REG_TARGET_HEIGHT],
                       cfg_regs[sqb_pkg::REG_CANVAS_HEIGHT]), 524287));
            q.tl = 17'(tex_coord(stored_ux[k], aw));
            q.tt = 17'(tex_coord(stored_uy[k], ah));
            q.tr = 17'(tex_coord(stored_ux[k] + stored_img[k].w, aw));
            q.tb = 17'(tex_coord(stored_uy[k] + stored_img[k].h, ah));
            q.rgba = {stored_img[k].color[31:8], 8'hff - stored_img[k].color[7:0]};
            q.eos = (k + 1 == n_stored);
            pending_quads.push_back(q);
        end
        cur_x = 0;
        row_y = 0;
        row_h = 0;
        atlas_w = 0;
        n_stored = 0;
        n_sets++;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        errors++;
        $display("%0t: quad %0d %s got 0x%0h, expected 0x%0h", $realtime, n_quads, field,
                 got, want);
    endtask

    task automatic check_quad(quad_t got, quad_t want);
        if (got.ux != want.ux) report("upload_x", got.ux, want.ux);
        if (got.uy != want.uy) report("upload_y", got.uy, want.uy);
        if (got.sl != want.sl) report("screen_left", got.sl, want.sl);
        if (got.st != want.st) report("screen_top", got.st, want.st);
        if (got.sr != want.sr) report("screen_right", got.sr, want.sr);
        if (got.sb != want.sb) report("screen_bottom", got.sb, want.sb);
        if (got.tl != want.tl) report("tex_left", got.tl, want.tl);
        if (got.tt != want.tt) report("tex_top", got.tt, want.tt);
        if (got.tr != want.tr) report("tex_right", got.tr, want.tr);
        if (got.tb != want.tb) report("tex_bottom", got.tb, want.tb);
        if (got.rgba != want.rgba) report("rgba", got.rgba, want.rgba);
        if (got.eos != want.eos) report("end_of_set", got.eos, want.eos);
    endtask

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_quads.size() == 0)
            begin
                errors++;
                $display("%0t: quad with none pending", $realtime);
            end
            else
                check_quad({upload_x, upload_y, screen_left, screen_top, screen_right,
                            screen_bottom, tex_left, tex_top, tex_right, tex_bottom, rgba,
                            end_of_set}, pending_quads.pop_front());
            n_quads++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("subimage_atlas_quad_builder verification failed");
            $finish;
        end
    end

    // receiver side
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [13:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {18'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_regs[idx] = value;
    endtask

    // called and returns at a falling edge
    task automatic send_image(image_t im);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {image_x, image_y, image_width, image_height, row_stride, packed_color, last} <= im;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        pack_image(im);
        n_images++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_quads.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic setup(logic [13:0] maxw, logic [13:0] tx, logic [13:0] ty,
                         logic [13:0] tw, logic [13:0] th, logic [13:0] cw,
                         logic [13:0] ch, int idle, int stall);
        drain();
        write_reg(sqb_pkg::REG_MAX_ATLAS_WIDTH, maxw);
        write_reg(sqb_pkg::REG_TARGET_X, tx);
        write_reg(sqb_pkg::REG_TARGET_Y, ty);
        write_reg(sqb_pkg::REG_TARGET_WIDTH, tw);
        write_reg(sqb_pkg::REG_TARGET_HEIGHT, th);
        write_reg(sqb_pkg::REG_CANVAS_WIDTH, cw);
        write_reg(sqb_pkg::REG_CANVAS_HEIGHT, ch);
        idle_pct = idle;
        stall_pct = stall;
        n_setups++;
    endtask

    function automatic image_t random_image(logic is_last);
        image_t im;
        im.x = 13'($urandom_range(0, 8191));
        im.y = 13'($urandom_range(0, 8191));
        im.w = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 4096))
                                           : 13'($urandom_range(0, 300));
        im.h = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 4096))
                                           : 13'($urandom_range(0, 300));
        im.stride = $urandom_range(0, 1) ? im.w : 13'($urandom_range(0, 4096));
        im.color = $urandom;
        im.last = is_last;
        return im;
    endfunction

    task automatic random_sets(int items);
        int size;
        while (items > 0)
        begin
            size = $urandom_range(1, 8);
            for (int i = 0; i < size; i++)
                send_image(random_image(i == size - 1));
            items -= size;
        end
    endtask

    // fixed-size images in one set, for the saturation and full-store cases
    task automatic uniform_set(int count, logic [12:0] w, logic [12:0] h,
                               logic [12:0] stride);
        image_t im;
        for (int i = 0; i < count; i++)
        begin
            im = random_image(i == count - 1);
            im.w = w;
            im.h = h;
            im.stride = stride;
            send_image(im);
        end
    endtask

    dir_row_t dir_table [0:11] = '{
        '{'{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 32'h0000_00ff, 1'b1}, 1'b1,
          '{16'd0, 16'd0, 19'd0, 19'd0, 19'd0, 19'd0, 17'd0, 17'd0, 17'd0, 17'd0,
            32'h0000_0000, 1'b1}},
        '{'{13'd8191, 13'd8191, 13'd4096, 13'd4096, 13'd4096, 32'hffff_ff00, 1'b1}, 1'b1,
          '{16'd0, 16'd0, 19'd0, 19'd0, 19'd0, 19'd0, 17'd0, 17'd0, 17'h10000, 17'h10000,
            32'hffff_ffff, 1'b1}},
        // shelf wrap on stride, tallest image sets row height
        '{'{13'd10, 13'd20, 13'd1000, 13'd30, 13'd1000, 32'h1234_5678, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'd30, 13'd40, 13'd2000, 13'd50, 13'd2000, 32'h8765_4321, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'd50, 13'd60, 13'd1500, 13'd10, 13'd1200, 32'haaaa_5555, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'd70, 13'd80, 13'd4096, 13'd4096, 13'd4096, 32'h5555_aaaa, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'd90, 13'd99, 13'd0, 13'd0, 13'd0, 32'h0f0f_0f0f, 1'b1}, 1'b0, NO_QUAD},
        // stride exactly at the wrap width does not wrap
        '{'{13'd1, 13'd2, 13'd96, 13'd7, 13'd4000, 32'hdead_beef, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'd3, 13'd4, 13'd5, 13'd4095, 13'd4000, 32'hcafe_f00d, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'd4095, 13'd4096, 13'd4095, 13'd1, 13'd4001, 32'h0102_0304, 1'b1},
          1'b0, NO_QUAD},
        '{'{13'h0aaa, 13'h1555, 13'd0, 13'd2, 13'd0, 32'hffff_ffff, 1'b0}, 1'b0, NO_QUAD},
        '{'{13'h1555, 13'h0aaa, 13'd2730, 13'd0, 13'd2730, 32'h0000_0000, 1'b1},
          1'b0, NO_QUAD}
    };

    initial
    begin
        cfg_regs = '{14'd4096, 14'd0, 14'd0, 14'd0, 14'd0, 14'd1, 14'd1};
        cur_x = 0;
        row_y = 0;
        row_h = 0;
        atlas_w = 0;
        n_stored = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows at reset register values
        foreach (dir_table[i])
        begin
            send_image(dir_table[i].img);
            if (dir_table[i].typed)
            begin
                void'(pending_quads.pop_back());
                pending_quads.push_back(dir_table[i].want);
            end
        end

        // no wrapping, cursor saturates past 65535
        setup(14'd0, 14'd100, 14'd50, 14'd1920, 14'd1080, 14'd1920, 14'd1080, 0, 0);
        uniform_set(17, 13'd4096, 13'd8, 13'd4096);
        random_sets(20);

        // maximum target, wrap width 8192, screen edges saturate
        setup(14'd8192, 14'd16383, 14'd16383, 14'd16383, 14'd16383, 14'd1, 14'd1, 73, 0);
        random_sets(20);

        // zero canvas, every image of the uniform set wraps, row top saturates
        setup(14'd1, 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
              14'd0, 14'd0, 0, 73);
        uniform_set(18, 13'd16, 13'd4096, 13'd4096);
        random_sets(20);

        // store full: the extra images are dropped, their last bit ends the set
        setup(14'($urandom_range(0, 8192)), 14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383)), 14'($urandom_range(1, 8192)),
              14'($urandom_range(1, 8192)), 19, 19);
        uniform_set(66, 13'd200, 13'd20, 13'd200);
        random_sets(20);

        // receiver holds off while the sender keeps offering, then sender waits
        setup(14'($urandom_range(0, 8192)), 14'($urandom_range(0, 2000)),
              14'($urandom_range(0, 2000)), 14'($urandom_range(0, 4000)),
              14'($urandom_range(0, 4000)), 14'($urandom_range(1, 8192)),
              14'($urandom_range(1, 8192)), 0, 0);
        hold_req = 3000;
        random_sets(15);
        drain();
        random_sets(15);

        setup(14'($urandom_range(0, 8192)), 14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383)), 14'($urandom_range(1, 8192)),
              14'($urandom_range(1, 8192)), 73, 73);
        random_sets(15);

        drain();
        repeat (300) @(posedge clk);
        $display("%0d images in %0d sets over %0d register setups, %0d quads checked",
                 n_images, n_sets, n_setups, n_quads);
        $display("covered wrap, no-wrap, saturation, zero canvas, full store and back pressure");
        if (errors == 0 && pending_quads.size() == 0)
            $display("subimage_atlas_quad_builder verification clean");
        else
            $display("subimage_atlas_quad_builder verification failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/sqb_pkg.sv
rtl/core/sqb_ram.sv
rtl/core/sqb_div.sv
rtl/core/sqb_pack.sv
rtl/core/subimage_atlas_quad_builder.sv
verif/testbench.sv
